>>> rtl/core/mst_pkg.sv
// Shared types, codes and default sizes for the counted multiset table.
package mst_pkg;

    // Fixed field widths.
    localparam int KEY_W    = 32;
    localparam int REQ_W    = 3;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_COUNT_BITS = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ERASE_ONE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ERASE_ALL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COUNT     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LIST      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd6;

    // Reply kinds.
    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COUNT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SATURATED = 2'd3;

    // One request beat.
    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [KEY_W-1:0] key;
    } req_t;

    // One result beat.
    typedef struct packed {
        logic [KIND_W-1:0]       reply_kind;
        logic [STATUS_W-1:0]     status;
        logic                    found;
        logic [OCC_W-1:0]        occurrences;
        logic signed [KEY_W-1:0] entry_key;
        logic                    entry_valid;
        logic                    last;
    } rsp_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_SHUP,
        ST_SHDN,
        ST_LIST
    } state_t;

    // Builds a result beat from its fields.
    function automatic rsp_t make_rsp(
        input logic [KIND_W-1:0]   kind,
        input logic [STATUS_W-1:0] status,
        input logic                found,
        input logic [OCC_W-1:0]    occ,
        input logic [KEY_W-1:0]    ekey,
        input logic                evalid,
        input logic                last
    );
        rsp_t r;
        r.reply_kind  = kind;
        r.status      = status;
        r.found       = found;
        r.occurrences = occ;
        r.entry_key   = ekey;
        r.entry_valid = evalid;
        r.last        = last;
        return r;
    endfunction

endpackage

>>> rtl/core/mst_mem.sv
// Entry store: one write port and one registered read port.
module mst_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mst_ctrl.sv
// Request sequencer: scans, updates and shifts the sorted entry store.
module mst_ctrl #(
    parameter int CAPACITY   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  mst_pkg::req_t                               req,
    output logic                                        busy,
    output mst_pkg::rsp_t                               result,
    output logic                                        result_valid,
    output logic                                        mem_we,
    output logic [$clog2(CAPACITY)-1:0]                 mem_waddr,
    output logic [mst_pkg::KEY_W+COUNT_BITS-1:0]        mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]                 mem_raddr,
    input  logic [mst_pkg::KEY_W+COUNT_BITS-1:0]        mem_rdata
);

    import mst_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int USED_W = $clog2(CAPACITY + 1);
    localparam int ENT_W  = KEY_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [USED_W-1:0]     USED_ONE = USED_W'(1);
    localparam logic [USED_W-1:0]     USED_CAP = USED_W'(CAPACITY);

    state_t                  state_reg, state_next;
    req_t                    req_reg, req_next;
    logic [USED_W-1:0]       used_reg, used_next;
    logic [USED_W-1:0]       ptr_reg, ptr_next;
    logic [USED_W-1:0]       pos_reg, pos_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        apend_reg, apend_next;
    logic                    present_reg, present_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    rsp_t                    res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;

    logic [KEY_W-1:0]        rd_key;
    logic [COUNT_BITS-1:0]   rd_cnt;
    logic                    key_lt;
    logic                    scan_hit;
    logic                    scan_end;
    logic [USED_W-1:0]       apend_ext;
    logic [USED_W-1:0]       ptr_dec;
    logic                    list_last;

    // Low bits of a count, zero-extended when counts are narrow.
    function automatic logic [OCC_W-1:0] occ_of(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+OCC_W-1:0] ext;
        ext = {{OCC_W{1'b0}}, c};
        return ext[OCC_W-1:0];
    endfunction

    // Fields of the entry read in the previous cycle.
    assign rd_key    = mem_rdata[ENT_W-1 -: KEY_W];
    assign rd_cnt    = mem_rdata[COUNT_BITS-1:0];
    assign key_lt    = $signed(rd_key) < $signed(req_reg.key);
    assign scan_hit  = pend_reg && !key_lt;
    assign scan_end  = !scan_hit && (ptr_reg >= used_reg);
    assign apend_ext = USED_W'(apend_reg);
    assign ptr_dec   = ptr_reg - USED_ONE;
    assign list_last = (apend_ext + USED_ONE) == used_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.req_type) inside
                        REQ_ADD, REQ_ERASE_ONE, REQ_ERASE_ALL, REQ_FIND, REQ_COUNT:
                            state_next = ST_SCAN;
                        REQ_LIST:
                            state_next = (used_reg == '0) ? ST_IDLE : ST_LIST;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_end)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                state_next = ST_IDLE;
                case (req_reg.req_type) inside
                    REQ_ADD:
                    begin
                        if (!present_reg && used_reg != USED_CAP)
                        begin
                            state_next = ST_SHUP;
                        end
                    end
                    REQ_ERASE_ONE, REQ_ERASE_ALL:
                    begin
                        if (present_reg &&
                            !(req_reg.req_type == REQ_ERASE_ONE && cnt_reg > CNT_ONE))
                        begin
                            state_next = ST_SHDN;
                        end
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_SHUP:
            begin
                if (ptr_reg <= pos_reg && !pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHDN:
            begin
                if (ptr_reg >= used_reg && !pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                if (pend_reg && list_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory access and result beats.
    always_comb
    begin
        req_next       = req_reg;
        used_next      = used_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        pend_next      = 1'b0;
        apend_next     = apend_reg;
        present_next   = present_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = apend_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    ptr_next = '0;
                    if (req.req_type == REQ_CLEAR)
                    begin
                        used_next      = '0;
                        res_next       = make_rsp(KIND_CLEAR, STAT_OK, 1'b0, '0, '0,
                                                  1'b0, 1'b1);
                        res_valid_next = 1'b1;
                    end
                    else if (req.req_type == REQ_LIST && used_reg == '0)
                    begin
                        res_next       = make_rsp(KIND_LIST, STAT_OK, 1'b0, '0, '0,
                                                  1'b0, 1'b1);
                        res_valid_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // Walk up from entry 0 until a key not below the request key.
                if (scan_hit)
                begin
                    pos_next     = apend_ext;
                    present_next = (rd_key == req_reg.key);
                    cnt_next     = (rd_key == req_reg.key) ? rd_cnt : '0;
                end
                else if (scan_end)
                begin
                    pos_next     = used_reg;
                    present_next = 1'b0;
                    cnt_next     = '0;
                end
                else
                begin
                    pend_next  = 1'b1;
                    apend_next = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_reg + USED_ONE;
                end
            end
            ST_ACT:
            begin
                res_valid_next = 1'b1;
                case (req_reg.req_type) inside
                    REQ_ADD:
                    begin
                        if (present_reg)
                        begin
                            if (cnt_reg == CNT_MAX)
                            begin
                                res_next = make_rsp(KIND_ADD, STAT_SATURATED, 1'b1,
                                                    occ_of(cnt_reg), '0, 1'b0, 1'b1);
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_reg[IDX_W-1:0];
                                mem_wdata = {req_reg.key, cnt_reg + CNT_ONE};
                                res_next  = make_rsp(KIND_ADD, STAT_OK, 1'b1,
                                                     occ_of(cnt_reg + CNT_ONE), '0,
                                                     1'b0, 1'b1);
                            end
                        end
                        else if (used_reg == USED_CAP)
                        begin
                            res_next = make_rsp(KIND_ADD, STAT_FULL, 1'b0, '0, '0,
                                                1'b0, 1'b1);
                        end
                        else
                        begin
                            // Open a gap at the insert position; result comes later.
                            res_valid_next = 1'b0;
                            ptr_next       = used_reg;
                        end
                    end
                    REQ_ERASE_ONE, REQ_ERASE_ALL:
                    begin
                        if (!present_reg)
                        begin
                            res_next = make_rsp(KIND_ERASE, STAT_ABSENT, 1'b0, '0, '0,
                                                1'b0, 1'b1);
                        end
                        else if (req_reg.req_type == REQ_ERASE_ONE && cnt_reg > CNT_ONE)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_reg[IDX_W-1:0];
                            mem_wdata = {req_reg.key, cnt_reg - CNT_ONE};
                            res_next  = make_rsp(KIND_ERASE, STAT_OK, 1'b1,
                                                 occ_of(cnt_reg - CNT_ONE), '0,
                                                 1'b0, 1'b1);
                        end
                        else
                        begin
                            // Close the gap over the removed entry; result comes later.
                            res_valid_next = 1'b0;
                            ptr_next       = pos_reg + USED_ONE;
                        end
                    end
                    REQ_FIND:
                    begin
                        res_next = make_rsp(KIND_FIND,
                                            present_reg ? STAT_OK : STAT_ABSENT,
                                            present_reg, occ_of(cnt_reg), '0,
                                            1'b0, 1'b1);
                    end
                    default:
                    begin
                        res_next = make_rsp(KIND_COUNT,
                                            present_reg ? STAT_OK : STAT_ABSENT,
                                            present_reg, occ_of(cnt_reg), '0,
                                            1'b0, 1'b1);
                    end
                endcase
            end
            ST_SHUP:
            begin
                // Move entries up by one, top first, then drop in the new key.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = apend_reg + IDX_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg > pos_reg)
                begin
                    mem_raddr  = ptr_dec[IDX_W-1:0];
                    apend_next = ptr_dec[IDX_W-1:0];
                    ptr_next   = ptr_dec;
                    pend_next  = 1'b1;
                end
                else if (!pend_reg)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = pos_reg[IDX_W-1:0];
                    mem_wdata      = {req_reg.key, CNT_ONE};
                    used_next      = used_reg + USED_ONE;
                    res_next       = make_rsp(KIND_ADD, STAT_OK, 1'b0, occ_of(CNT_ONE),
                                              '0, 1'b0, 1'b1);
                    res_valid_next = 1'b1;
                end
            end
            ST_SHDN:
            begin
                // Move entries above the removed one down by one, bottom first.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = apend_reg - IDX_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg < used_reg)
                begin
                    apend_next = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_reg + USED_ONE;
                    pend_next  = 1'b1;
                end
                else if (!pend_reg)
                begin
                    used_next      = used_reg - USED_ONE;
                    res_next       = make_rsp(KIND_ERASE, STAT_OK, 1'b1, '0, '0,
                                              1'b0, 1'b1);
                    res_valid_next = 1'b1;
                end
            end
            ST_LIST:
            begin
                // One beat per entry as each read returns.
                if (pend_reg)
                begin
                    res_next       = make_rsp(KIND_LIST, STAT_OK, 1'b0, occ_of(rd_cnt),
                                              rd_key, 1'b1, list_last);
                    res_valid_next = 1'b1;
                end
                if (ptr_reg < used_reg)
                begin
                    apend_next = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_reg + USED_ONE;
                    pend_next  = 1'b1;
                end
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        ptr_reg     <= ptr_next;
        pos_reg     <= pos_next;
        apend_reg   <= apend_next;
        present_reg <= present_next;
        cnt_reg     <= cnt_next;
        res_reg     <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    // The table never holds more entries than it has room for.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_CAP)
        else $error("entry count exceeds capacity");

    // The store is only written while a request is in progress.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != ST_IDLE)
        else $error("store written while idle");

    // An insert shift only starts when a free entry exists.
    a_shup_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHUP |-> used_reg < USED_CAP)
        else $error("insert shift on a full table");

    // A clear empties the table at once.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && req.req_type == REQ_CLEAR) |=>
        (used_reg == '0 && res_valid_reg))
        else $error("clear did not empty the table");

endmodule

>>> rtl/core/counted_multiset_table.sv
// Top level of the counted multiset table: sequencer plus entry store.
//
// A request beat (req) is taken at a rising edge where start is high and busy
// is low. Each request except an unknown code produces one result beat; a list
// request produces one beat per distinct key in ascending order, or a single
// beat with entry_valid low when the table is empty. The last beat of a
// request has last set. Each result beat sits on result for exactly one cycle
// with result_valid high; the receiver cannot stall it.
// Clear and an empty list answer in the cycle after they are taken, with
// busy staying low. Other requests first scan the sorted store from entry 0,
// one entry per cycle, then take a decision step. An insert or a remove then
// moves the entries above the key by one place, one entry at a time. A list
// gives one beat per cycle. The single read port and single write port of
// the store are why entries are handled one at a time.
// Reset empties the table at once; no clearing pass runs, since entries at
// or above the used count are never read.
module counted_multiset_table #(
    parameter int CAPACITY   = mst_pkg::DEF_CAPACITY,
    parameter int COUNT_BITS = mst_pkg::DEF_COUNT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mst_pkg::req_t req,
    output logic          busy,
    output mst_pkg::rsp_t result,
    output logic          result_valid
);

    import mst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ENT_W = KEY_W + COUNT_BITS;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    // Request sequencer.
    mst_ctrl #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // Sorted key and count store.
    mst_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the counted multiset table: directed, fill, repeated key, random.
`timescale 1ns / 1ps

module tb;
    import mst_pkg::*;

    localparam int CAPACITY   = DEF_CAPACITY;
    localparam int COUNT_BITS = DEF_COUNT_BITS;
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int MAX_REPORTS  = 40;
    localparam int POOL_SIZE    = 48;

    // Request code that the block ignores.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

    // Key extremes.
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // One row of the directed part: a request and, where known, its single result.
    typedef struct {
        logic [REQ_W-1:0]        op;
        logic signed [KEY_W-1:0] key;
        bit                      known;
        rsp_t                    want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    rsp_t result;
    logic result_valid;

    // Shadow copy of the table contents, kept in ascending key order.
    logic signed [KEY_W-1:0] tbl_key [CAPACITY];
    logic [31:0]             tbl_cnt [CAPACITY];
    int                      used = 0;

    rsp_t      due_results [$];
    plan_row_t plan [$];
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
    int  bad_beats = 0;
    int  cycles = 0;
    bit  steady = 1'b0;

    counted_multiset_table #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    always #5 clk = ~clk;

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // A single-beat answer; these never carry a listed entry.
    function automatic rsp_t answer(input logic [KIND_W-1:0] kind,
                                    input logic [STATUS_W-1:0] stat,
                                    input logic fnd, input logic [31:0] occ);
        rsp_t r;
        r = '0;
        r.reply_kind  = kind;
        r.status      = stat;
        r.found       = fnd;
        r.occurrences = occ[OCC_W-1:0];
        r.last        = 1'b1;
        return r;
    endfunction

    // Appends one expected beat to the tail of the queue.
    function automatic void queue_beat(input rsp_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    // Applies one accepted request to the shadow table and queues its results.
    task automatic apply_request(input req_t rq);
        int pos;
        int i;
        bit hit;
        logic [31:0] cnt;
        rsp_t r;
        pos = 0;
        while (pos < used && tbl_key[pos] < rq.key)
            pos++;
        hit = (pos < used) && (tbl_key[pos] == rq.key);
        cnt = hit ? tbl_cnt[pos] : 32'd0;
        case (rq.req_type)
            REQ_ADD:
            begin
                if (hit && cnt >= CNT_MAX)
                    queue_beat(answer(KIND_ADD, STAT_SATURATED, 1'b1, cnt));
                else if (hit)
                begin
                    tbl_cnt[pos] = cnt + 1;
                    queue_beat(answer(KIND_ADD, STAT_OK, 1'b1, cnt + 1));
                end
                else if (used >= CAPACITY)
                    queue_beat(answer(KIND_ADD, STAT_FULL, 1'b0, 32'd0));
                else
                begin
                    // Open a slot at the insert point.
                    for (i = used; i > pos; i--)
                    begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_cnt[i] = tbl_cnt[i-1];
                    end
                    tbl_key[pos] = rq.key;
                    tbl_cnt[pos] = 32'd1;
                    used++;
                    queue_beat(answer(KIND_ADD, STAT_OK, 1'b0, 32'd1));
                end
            end
            REQ_ERASE_ONE, REQ_ERASE_ALL:
            begin
                if (!hit)
                    queue_beat(answer(KIND_ERASE, STAT_ABSENT, 1'b0, 32'd0));
                else
                begin
                    if (rq.req_type == REQ_ERASE_ONE && cnt > 1)
                    begin
                        cnt = cnt - 1;
                        tbl_cnt[pos] = cnt;
                    end
                    else
                    begin
                        // Close the gap left by the removed key.
                        for (i = pos; i + 1 < used; i++)
                        begin
                            tbl_key[i] = tbl_key[i+1];
                            tbl_cnt[i] = tbl_cnt[i+1];
                        end
                        used--;
                        cnt = 32'd0;
                    end
                    queue_beat(answer(KIND_ERASE, STAT_OK, 1'b1, cnt));
                end
            end
            REQ_FIND, REQ_COUNT:
            begin
                queue_beat(answer(rq.req_type == REQ_FIND ? KIND_FIND : KIND_COUNT,
                                  hit ? STAT_OK : STAT_ABSENT, hit, cnt));
            end
            REQ_LIST:
            begin
                if (used == 0)
                    queue_beat(answer(KIND_LIST, STAT_OK, 1'b0, 32'd0));
                for (i = 0; i < used; i++)
                begin
                    r = '0;
                    r.reply_kind  = KIND_LIST;
                    r.status      = STAT_OK;
                    r.occurrences = tbl_cnt[i][OCC_W-1:0];
                    r.entry_key   = tbl_key[i];
                    r.entry_valid = 1'b1;
                    r.last        = (i == used - 1);
                    queue_beat(r);
                end
            end
            REQ_CLEAR:
            begin
                used = 0;
                queue_beat(answer(KIND_CLEAR, STAT_OK, 1'b0, 32'd0));
            end
            default:
            begin
            end
        endcase
    endtask

    // Drives one request beat, after a random gap unless steady is set, and waits until it is taken.
    task automatic issue(input logic [REQ_W-1:0] op, input logic signed [KEY_W-1:0] k,
                         input bit known = 1'b0, input rsp_t want = '0);
        req_t rq;
        int gap;
        int mark;
        rq.req_type = op;
        rq.key      = k;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= rq;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // The beat was taken at this edge.
        mark = due_results.size();
        apply_request(rq);
        if (known)
        begin
            while (due_results.size() > mark)
                due_results.delete(due_results.size() - 1);
            queue_beat(want);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            bad_beats++;
            if (bad_beats <= MAX_REPORTS)
                $display("%0t: result %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // Result beats are taken at the edge that ends their strobe cycle.
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= MAX_REPORTS)
                    $display("%0t: result beat with none expected, actual %0h",
                             $time, result);
            end
            else
            begin
                want = due_results.pop_front();
                check_field("reply_kind", 32'(want.reply_kind), 32'(result.reply_kind));
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("found", 32'(want.found), 32'(result.found));
                check_field("occurrences", 32'(want.occurrences), 32'(result.occurrences));
                check_field("entry_key", want.entry_key, result.entry_key);
                check_field("entry_valid", 32'(want.entry_valid), 32'(result.entry_valid));
                check_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    function automatic void plan_row(input logic [REQ_W-1:0] op,
                                     input logic signed [KEY_W-1:0] k);
        plan_row_t p;
        p.op    = op;
        p.key   = k;
        p.known = 1'b0;
        p.want  = '0;
        plan.insert(plan.size(), p);
    endfunction

    function automatic void plan_known(input logic [REQ_W-1:0] op,
                                       input logic signed [KEY_W-1:0] k,
                                       input logic [KIND_W-1:0] kind,
                                       input logic [STATUS_W-1:0] stat,
                                       input logic fnd, input logic [31:0] occ);
        plan_row_t p;
        p.op    = op;
        p.key   = k;
        p.known = 1'b1;
        p.want  = answer(kind, stat, fnd, occ);
        plan.insert(plan.size(), p);
    endfunction

    initial
    begin : stimulus
        int done;
        int pick;
        int i;
        logic [REQ_W-1:0] op;
        logic signed [KEY_W-1:0] k;

        // Directed part: empty table, extremes, absent keys, ignored code, clear.
        plan_known(REQ_LIST, 0, KIND_LIST, STAT_OK, 1'b0, 0);
        plan_known(REQ_FIND, 0, KIND_FIND, STAT_ABSENT, 1'b0, 0);
        plan_known(REQ_COUNT, KEY_MIN, KIND_COUNT, STAT_ABSENT, 1'b0, 0);
        plan_known(REQ_ERASE_ONE, 5, KIND_ERASE, STAT_ABSENT, 1'b0, 0);
        plan_known(REQ_ERASE_ALL, KEY_MAX, KIND_ERASE, STAT_ABSENT, 1'b0, 0);
        plan_known(REQ_ADD, KEY_MAX, KIND_ADD, STAT_OK, 1'b0, 1);
        plan_known(REQ_ADD, KEY_MIN, KIND_ADD, STAT_OK, 1'b0, 1);
        plan_known(REQ_ADD, 0, KIND_ADD, STAT_OK, 1'b0, 1);
        plan_row(REQ_ADD, KEY_MAX);
        plan_row(REQ_ADD, -1);
        plan_row(REQ_ADD, KEY_MIN);
        plan_row(REQ_FIND, KEY_MAX);
        plan_row(REQ_COUNT, KEY_MIN);
        plan_row(REQ_COUNT, 0);
        plan_row(REQ_LIST, 0);
        plan_row(REQ_ERASE_ONE, KEY_MAX);
        plan_row(REQ_ERASE_ALL, KEY_MIN);
        plan_row(REQ_ERASE_ONE, 0);
        plan_known(REQ_ERASE_ONE, 0, KIND_ERASE, STAT_ABSENT, 1'b0, 0);
        plan_row(REQ_LIST, 0);
        plan_row(REQ_UNKNOWN, 32'sh5a5a_a5a5);
        plan_known(REQ_CLEAR, 0, KIND_CLEAR, STAT_OK, 1'b0, 0);
        plan_known(REQ_LIST, 0, KIND_LIST, STAT_OK, 1'b0, 0);
        plan_known(REQ_FIND, KEY_MAX, KIND_FIND, STAT_ABSENT, 1'b0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[j])
            issue(plan[j].op, plan[j].key, plan[j].known, plan[j].want);

        // Fill the table to capacity, then push adds past it.
        issue(REQ_CLEAR, $urandom);
        while (used < CAPACITY)
            issue(REQ_ADD, $urandom);
        issue(REQ_LIST, $urandom);
        for (i = 0; i < 3; i++)
            issue(REQ_ADD, $urandom);
        issue(REQ_ADD, tbl_key[$urandom_range(0, CAPACITY - 1)]);
        issue(REQ_FIND, tbl_key[$urandom_range(0, CAPACITY - 1)]);
        issue(REQ_ERASE_ALL, tbl_key[0]);
        issue(REQ_ADD, KEY_MIN);
        issue(REQ_ERASE_ALL, tbl_key[CAPACITY - 1]);
        issue(REQ_ADD, KEY_MAX);
        issue(REQ_ADD, $urandom);
        issue(REQ_LIST, 0);

        // Raise one key's count back to back, then walk it down again.
        steady = 1'b1;
        issue(REQ_CLEAR, 0);
        k = $urandom;
        for (done = 0; done < 4; done++)
            issue(REQ_ADD, k);
        issue(REQ_ERASE_ONE, k);
        issue(REQ_ADD, k);
        issue(REQ_ADD, k);
        issue(REQ_ADD, k ^ 32'sh0000_0001);
        issue(REQ_COUNT, k);
        issue(REQ_LIST, 0);
        issue(REQ_ERASE_ALL, k);
        issue(REQ_CLEAR, 0);
        steady = 1'b0;

        // Random part: keys mostly from a small pool so that hits and a full table are common.
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        for (i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 29) == 0)
                steady = !steady;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = REQ_ADD;
            else if (pick < 54)
                op = REQ_ERASE_ONE;
            else if (pick < 62)
                op = REQ_ERASE_ALL;
            else if (pick < 71)
                op = REQ_FIND;
            else if (pick < 80)
                op = REQ_COUNT;
            else if (pick < 88)
                op = REQ_LIST;
            else if (pick < 92)
                op = REQ_CLEAR;
            else
                op = REQ_UNKNOWN;
            if ($urandom_range(0, 9) < 8)
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                k = $urandom;
            issue(op, k);
            if (op != REQ_UNKNOWN)
                done++;
        end
        start <= 1'b0;

        // Let every expected beat arrive, then allow for stray ones.
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bad_beats == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
